FILE: rtl/zssd_pkg.sv
// zssd_pkg: shared constants, types and helpers for the zero-sum run detector
// no dependencies

package zssd_pkg;

   localparam int MAX_LEN   = 1024;
   localparam int ELEM_BITS = 16;
   localparam int ADDR_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_BITS  = $clog2(MAX_LEN + 1);
   // a sum of MAX_LEN elements needs ADDR_BITS growth; one guard bit is added
   localparam int SUM_BITS  = ELEM_BITS + ADDR_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                 go;
      logic [ADDR_BITS-1:0] last_addr;
   } scan_ctrl_type;

   typedef struct packed {
      logic hit;
      logic done;
   } scan_stat_type;

   function automatic logic [SUM_BITS-1:0] sext_elem(input logic [ELEM_BITS-1:0] e);
      sext_elem = {{(SUM_BITS-ELEM_BITS){e[ELEM_BITS-1]}}, e};
   endfunction

endpackage

FILE: rtl/zero_sum_subarray_detect.sv
// zero_sum_subarray_detect: top level, sequencer and per-sequence state
// depends on zssd_pkg, zssd_ram, zssd_scan
//
// Usage: present an element on req_element with req_is_last and raise start;
// the transaction is taken at an edge where start is high and busy is low.
// Each element adds to a running prefix sum that is compared with zero and
// with every earlier stored prefix, the latter one prefix-store read per cycle
// through a single shared comparator, then stored. An element keeps busy high
// until the scan of all stored prefixes and the store write are done; the
// single ram port serialises those reads. Elements beyond MAX_LEN only set the
// overflow flag.
// On the last element one result appears on rsp_found / rsp_overflow with
// rsp_valid high for exactly one cycle, registered at the edge of the store
// write (or the accept edge for an overflowing element); then all per-sequence
// state is cleared. The receiver cannot stall the result.
// Reset clears the sum, count and flags at once; no clearing pass is needed
// since only prefixes written in the current sequence are ever read.

module zero_sum_subarray_detect import zssd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [ELEM_BITS-1:0] req_element,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic                        rsp_overflow
);

   state_type            state_ff, state_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 found_ff, found_in;
   logic                 overflow_ff, overflow_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   scan_ctrl_type        scan_ctrl;
   scan_stat_type        scan_stat;
   logic [ADDR_BITS-1:0] scan_addr;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [SUM_BITS-1:0]  ram_rd_data;
   logic                 ram_wr_en;
   logic                 accept;
   logic                 full;
   logic                 found_now;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(MAX_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff         <= last_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   always_comb begin
      state_in        = state_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      found_in        = found_ff | scan_stat.hit;
      overflow_in     = overflow_ff;
      last_in         = last_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_overflow_in = rsp_overflow_ff;
      scan_ctrl.go        = 1'b0;
      scan_ctrl.last_addr = ADDR_BITS'(count_ff - 1'b1);
      ram_wr_en       = 1'b0;
      found_now       = found_ff | (sum_ff == '0);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  // element past the store depth only marks overflow, or emits the result if last
                  if (req_is_last) begin
                     rsp_valid_in    = 1'b1;
                     rsp_found_in    = found_ff;
                     rsp_overflow_in = 1'b1;
                     sum_in          = '0;
                     count_in        = '0;
                     found_in        = 1'b0;
                     overflow_in     = 1'b0;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  sum_in  = sum_ff + sext_elem(req_element);
                  last_in = req_is_last;
                  if (count_ff == '0) begin
                     state_in = ST_WRITE;
                  end else begin
                     scan_ctrl.go = 1'b1;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            state_in  = ST_IDLE;
            if (last_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = found_now;
               rsp_overflow_in = overflow_ff;
               sum_in          = '0;
               count_in        = '0;
               found_in        = 1'b0;
               overflow_in     = 1'b0;
            end else begin
               found_in = found_now;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_addr = (state_ff == ST_WRITE) ? ADDR_BITS'(count_ff) : scan_addr;

   zssd_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (scan_ctrl),
      .rd_data (ram_rd_data),
      .sum     (sum_ff),
      .rd_addr (scan_addr),
      .stat    (scan_stat)
   );

   zssd_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_LEN)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (sum_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

FILE: rtl/zssd_ram.sv
// zssd_ram: generic single-port ram with registered read data
// no dependencies

module zssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  logic [WIDTH-1:0]                 wr_data,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/zssd_scan.sv
// zssd_scan: walks the stored prefixes one read per cycle and runs the shared
// equality compare against the current prefix sum; uses zssd_pkg

module zssd_scan import zssd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctrl_type        ctrl,
   input  logic [SUM_BITS-1:0]  rd_data,
   input  logic [SUM_BITS-1:0]  sum,
   output logic [ADDR_BITS-1:0] rd_addr,
   output scan_stat_type        stat
);

   logic                 active_ff, active_in;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   logic                 chk_ff, chk_in;
   logic                 chk_last_ff, chk_last_in;

   always_comb begin
      active_in   = active_ff;
      idx_in      = idx_ff;
      chk_in      = active_ff;
      chk_last_in = 1'b0;
      if (ctrl.go) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (active_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == ctrl.last_addr) begin
            active_in   = 1'b0;
            chk_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         chk_ff      <= 1'b0;
         chk_last_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         chk_ff      <= chk_in;
         chk_last_ff <= chk_last_in;
      end
      idx_ff <= idx_in;
   end

   assign rd_addr = idx_ff;

   // read data lags the address by the ram's read register; chk_ff lags to match
   assign stat.hit  = chk_ff && (rd_data == sum);
   assign stat.done = chk_last_ff;

endmodule

FILE: bench/zero_sum_subarray_detect_tb.sv
// zero_sum_subarray_detect_tb: self-checking bench for the zero-sum run detector
// a table of directed sequences, one sequence past the prefix store depth, then random
// sequences in several pacing phases; depends on zssd_pkg and zero_sum_subarray_detect
`timescale 1ns / 100ps

module zero_sum_subarray_detect_tb import zssd_pkg::*; ();

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int RANDOM_ITEMS  = 580;
   localparam int PHASE_COUNT   = 6;
   localparam int DIR_ROWS      = 22;
   localparam int OVERFLOW_LEN  = MAX_LEN + 2;

   typedef struct packed {
      logic found;
      logic overflow;
   } verdict_type;

   typedef struct packed {
      logic signed [ELEM_BITS-1:0] elem;
      logic                        last;
      logic                        typed;
      logic                        t_found;
      logic                        t_ovf;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [ELEM_BITS-1:0] req_element = '0;
   logic                        req_is_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_found;
   logic                        rsp_overflow;

   // predictor state for the sequence in progress
   logic signed [SUM_BITS-1:0]  prefix_hist[$];
   logic signed [SUM_BITS-1:0]  run_sum      = '0;
   bit                          seq_found    = 1'b0;
   bit                          seq_overflow = 1'b0;

   verdict_type                 pending_verdicts[$];
   int                          mismatch_count = 0;
   int                          cycle_count    = 0;

   // typed expectations only on rows whose answer is obvious
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{16'sh0000, 1'b1, 1'b1, 1'b1, 1'b0},   // lone zero element
      '{16'sh7fff, 1'b1, 1'b1, 1'b0, 1'b0},
      '{16'sh8000, 1'b1, 1'b1, 1'b0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sh8001, 1'b1, 1'b1, 1'b1, 1'b0},   // whole sequence sums to zero
      '{16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sh7fff, 1'b1, 1'b0, 1'b0, 1'b0},
      '{16'sd5,    1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},   // zero in the middle
      '{16'sd7,    1'b1, 1'b1, 1'b1, 1'b0},
      '{16'sd1,    1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sd2,    1'b0, 1'b0, 1'b0, 1'b0},
      '{-16'sd3,   1'b1, 1'b1, 1'b1, 1'b0},
      '{16'sd3,    1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sd4,    1'b0, 1'b0, 1'b0, 1'b0},
      '{-16'sd4,   1'b0, 1'b0, 1'b0, 1'b0},   // matches an earlier stored prefix
      '{16'sd9,    1'b1, 1'b0, 1'b0, 1'b0},
      '{-16'sd1,   1'b0, 1'b0, 1'b0, 1'b0},
      '{16'sh5555, 1'b0, 1'b0, 1'b0, 1'b0},
      '{16'shaaaa, 1'b1, 1'b0, 1'b0, 1'b0}
   };

   int idle_by_phase [3] = '{0, 56, 8};

   zero_sum_subarray_detect dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_element  (req_element),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_overflow (rsp_overflow)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // advance the prefix-sum model by one accepted element
   function automatic void step_prefix_model(input logic signed [ELEM_BITS-1:0] value,
                                             input logic last, output bit emit,
                                             output bit f, output bit ov);
      logic signed [SUM_BITS-1:0] next_sum;
      emit = 1'b0;
      f    = 1'b0;
      ov   = 1'b0;
      if (prefix_hist.size() >= MAX_LEN) begin
         seq_overflow = 1'b1;
      end else begin
         next_sum = run_sum + value;
         if (next_sum == 0) seq_found = 1'b1;
         foreach (prefix_hist[k]) begin
            if (prefix_hist[k] == next_sum) seq_found = 1'b1;
         end
         prefix_hist.insert(prefix_hist.size(), next_sum);
         run_sum = next_sum;
      end
      if (last) begin
         emit = 1'b1;
         f    = seq_found;
         ov   = seq_overflow;
         prefix_hist.delete();
         run_sum      = '0;
         seq_found    = 1'b0;
         seq_overflow = 1'b0;
      end
   endfunction

   task automatic send_element(input logic signed [ELEM_BITS-1:0] value, input logic last,
                               input bit typed, input bit t_found, input bit t_ovf,
                               input int idle_pct);
      bit          emit;
      bit          f;
      bit          ov;
      verdict_type v;
      start       <= 1'b1;
      req_element <= value;
      req_is_last <= last;
      do @(posedge clock); while (busy);
      step_prefix_model(value, last, emit, f, ov);
      if (emit) begin
         v.found    = typed ? t_found : f;
         v.overflow = typed ? t_ovf : ov;
         pending_verdicts.insert(pending_verdicts.size(), v);
      end
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   // hold the sender off until every outstanding verdict has arrived
   task automatic wait_all_verdicts();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no transaction pending: found %0b overflow %0b",
                   rsp_found, rsp_overflow);
            mismatch_count++;
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_found !== exp_v.found) begin
               $error("found: expected %0b, actual %0b", exp_v.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_overflow !== exp_v.overflow) begin
               $error("overflow: expected %0b, actual %0b", exp_v.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic signed [ELEM_BITS-1:0] seq_buf[$];
      int phase_items;
      int seq_len;
      int kind;
      int pick;
      int tail_sum;
      int first;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         send_element(dir_rows[r].elem, dir_rows[r].last, dir_rows[r].typed,
                      dir_rows[r].t_found, dir_rows[r].t_ovf, 0);
      end
      wait_all_verdicts();

      // strictly rising prefixes, two elements past the store depth
      for (int n = 0; n < OVERFLOW_LEN; n++) begin
         send_element(16'($urandom_range(1, 32767)), n == OVERFLOW_LEN - 1,
                      1'b0, 1'b0, 1'b0, 0);
      end
      wait_all_verdicts();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASE_COUNT) begin
            pick = $urandom_range(99);
            if (pick < 70)      seq_len = $urandom_range(1, 12);
            else if (pick < 95) seq_len = $urandom_range(13, 40);
            else                seq_len = $urandom_range(41, 90);
            kind = $urandom_range(3);
            seq_buf.delete();
            for (int n = 0; n < seq_len; n++) begin
               if (kind == 1)
                  seq_buf.insert(seq_buf.size(), 16'($signed($urandom_range(8)) - 4));
               else
                  seq_buf.insert(seq_buf.size(), 16'($urandom));
            end
            // for kind 2, when the tail sum fits an element, force a zero-sum run ending on the last element
            if (kind == 2 && seq_len >= 2) begin
               first    = $urandom_range(0, seq_len - 2);
               tail_sum = 0;
               for (int k = first; k < seq_len - 1; k++) tail_sum += seq_buf[k];
               if (tail_sum >= -32767 && tail_sum <= 32767)
                  seq_buf[seq_len - 1] = 16'(-tail_sum);
            end
            foreach (seq_buf[n]) begin
               send_element(seq_buf[n], n == seq_len - 1, 1'b0, 1'b0, 1'b0,
                            idle_by_phase[ph % 3]);
            end
            phase_items += seq_len;
         end
         wait_all_verdicts();
      end

      repeat (MAX_LEN + 8) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d expected results never arrived", pending_verdicts.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
